### src/cpic_pkg.sv
// Package for the cascaded priority interrupt controller.
// Holds the operation codes, item and result types, and the priority picker.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cpic_pkg;

    // Number of controllers in the cascade: master and slave.
    localparam int CHIPS = 2;

    // Event codes carried in the op field.
    typedef enum logic [2:0] {
        OP_RAISE = 3'd0,
        OP_LOWER = 3'd1,
        OP_WRITE = 3'd2,
        OP_READ  = 3'd3,
        OP_ACK   = 3'd4,
        OP_POLL  = 3'd5
    } t_op;

    // Initialization sequencer steps.
    localparam logic [2:0] INIT_IDLE = 3'd0;
    localparam logic [2:0] INIT_ICW2 = 3'd2;
    localparam logic [2:0] INIT_ICW3 = 3'd3;
    localparam logic [2:0] INIT_ICW4 = 3'd4;

    // End-of-interrupt command codes (top three bits of a command write).
    localparam logic [2:0] EOI_NONSPEC     = 3'd1;
    localparam logic [2:0] EOI_ROT_NONSPEC = 3'd5;
    localparam logic [2:0] EOI_SPEC        = 3'd3;
    localparam logic [2:0] EOI_ROT_SPEC    = 3'd7;

    // Command register bit positions.
    localparam int CMD_INIT_BIT   = 4;
    localparam int CMD_OCW3_BIT   = 3;
    localparam int CMD_RR_BIT     = 1;
    localparam int CMD_RIS_BIT    = 0;
    localparam int ICW4_AEOI_BIT  = 1;

    // Reset values and fixed constants.
    localparam logic [7:0] MASK_RESET        = 8'hFF;
    localparam logic [7:0] MASTER_BASE_RESET = 8'h08;
    localparam logic [7:0] SLAVE_BASE_RESET  = 8'h70;
    localparam logic [7:0] BASE_MASK         = 8'hF8;
    localparam logic [2:0] SPURIOUS_LINE     = 3'd7;
    localparam logic [2:0] CASCADE_LINE      = 3'd2;

    // One input item.
    typedef struct packed {
        logic [2:0] op;
        logic [3:0] irq_line;
        logic       chip_select;
        logic       reg_select;
        logic [7:0] write_data;
    } t_item;

    // One result item.
    typedef struct packed {
        logic [7:0] read_data;
        logic       pending;
    } t_result;

    // Outcome of a priority search on one chip.
    typedef struct packed {
        logic       found;
        logic [2:0] line;
    } t_pick;

    // Lowest unmasked request wins, unless an in-service bit at or below it blocks.
    function automatic t_pick best_line(input logic [7:0] req, input logic [7:0] svc,
                                        input logic [7:0] mask);
        logic [7:0] live;
        t_pick      pick;
        live = req & ~mask;
        pick = '0;
        for (int i = 7; i >= 0; i--) begin
            if (live[i] || svc[i]) begin
                pick.found = live[i] & ~svc[i];
                pick.line  = 3'(i);
            end
        end
        return pick;
    endfunction

endpackage

`default_nettype wire

### src/cpic_if.sv
// Valid/ready channel interfaces for the cascaded priority interrupt controller.
// Depends on nothing; payload fields follow the item and result definitions.
`timescale 1ns / 1ps
`default_nettype none

// Input event channel.
interface cpic_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] op;
    logic [3:0] irq_line;
    logic       chip_select;
    logic       reg_select;
    logic [7:0] write_data;

    modport source (output valid, output op, output irq_line, output chip_select,
                    output reg_select, output write_data, input ready);
    modport sink   (input valid, input op, input irq_line, input chip_select,
                    input reg_select, input write_data, output ready);
endinterface

// Result channel.
interface cpic_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       pending;

    modport source (output valid, output read_data, output pending, input ready);
    modport sink   (input valid, input read_data, input pending, output ready);
endinterface

`default_nettype wire

### src/cpic_core.sv
// Register state of both controllers and the single-pass event logic.
// Depends on cpic_pkg for the item and result types and the priority picker.
`timescale 1ns / 1ps
`default_nettype none

module cpic_core (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_fire,
    input  wire cpic_pkg::t_item  i_item,
    output cpic_pkg::t_result     o_result
);

    logic [7:0] r_req  [cpic_pkg::CHIPS];
    logic [7:0] r_svc  [cpic_pkg::CHIPS];
    logic [7:0] r_mask [cpic_pkg::CHIPS];
    logic [2:0] r_step [cpic_pkg::CHIPS];
    logic       r_icw4 [cpic_pkg::CHIPS];
    logic [7:0] r_base [cpic_pkg::CHIPS];
    logic       r_aeoi [cpic_pkg::CHIPS];
    logic       r_ris  [cpic_pkg::CHIPS];

    logic [7:0] n_req  [cpic_pkg::CHIPS];
    logic [7:0] n_svc  [cpic_pkg::CHIPS];
    logic [7:0] n_mask [cpic_pkg::CHIPS];
    logic [2:0] n_step [cpic_pkg::CHIPS];
    logic       n_icw4 [cpic_pkg::CHIPS];
    logic [7:0] n_base [cpic_pkg::CHIPS];
    logic       n_aeoi [cpic_pkg::CHIPS];
    logic       n_ris  [cpic_pkg::CHIPS];

    cpic_pkg::t_pick w_slave_pick;
    cpic_pkg::t_pick w_master_pick;
    cpic_pkg::t_pick w_slave_after;
    logic [7:0]      w_req0_casc;
    logic [7:0]      w_slave_req;
    logic [7:0]      w_slave_svc;
    logic [2:0]      w_cmd;

    // Cascade refresh: slave deliverability drives master line two.
    assign w_slave_pick  = cpic_pkg::best_line(r_req[1], r_svc[1], r_mask[1]);
    assign w_req0_casc   = {r_req[0][7:3], w_slave_pick.found, r_req[0][1:0]};
    assign w_master_pick = cpic_pkg::best_line(w_req0_casc, r_svc[0], r_mask[0]);
    assign w_cmd         = i_item.write_data[7:5];

    // Slave state after taking its best request, and the refresh that follows.
    always_comb begin
        w_slave_req = r_req[1];
        w_slave_svc = r_svc[1];
        w_slave_req[w_slave_pick.line] = 1'b0;
        if (!r_aeoi[1]) begin
            w_slave_svc[w_slave_pick.line] = 1'b1;
        end
    end
    assign w_slave_after = cpic_pkg::best_line(w_slave_req, w_slave_svc, r_mask[1]);

    // Next-state and result logic for one event.
    always_comb begin
        for (int k = 0; k < cpic_pkg::CHIPS; k++) begin
            n_req[k]  = r_req[k];
            n_svc[k]  = r_svc[k];
            n_mask[k] = r_mask[k];
            n_step[k] = r_step[k];
            n_icw4[k] = r_icw4[k];
            n_base[k] = r_base[k];
            n_aeoi[k] = r_aeoi[k];
            n_ris[k]  = r_ris[k];
        end
        o_result = '0;

        case (cpic_pkg::t_op'(i_item.op))
            cpic_pkg::OP_RAISE: begin
                n_req[i_item.irq_line[3]][i_item.irq_line[2:0]] = 1'b1;
            end
            cpic_pkg::OP_LOWER: begin
                n_req[i_item.irq_line[3]][i_item.irq_line[2:0]] = 1'b0;
            end
            cpic_pkg::OP_WRITE: begin
                for (int k = 0; k < cpic_pkg::CHIPS; k++) begin
                    if (i_item.chip_select == 1'(k)) begin
                        if (!i_item.reg_select) begin
                            // Command register: init word one, status select or EOI.
                            if (i_item.write_data[cpic_pkg::CMD_INIT_BIT]) begin
                                n_step[k] = cpic_pkg::INIT_ICW2;
                                n_icw4[k] = i_item.write_data[0];
                                n_mask[k] = '0;
                                n_svc[k]  = '0;
                                n_req[k]  = '0;
                                n_aeoi[k] = 1'b0;
                                n_ris[k]  = 1'b0;
                            end else if (i_item.write_data[cpic_pkg::CMD_OCW3_BIT]) begin
                                if (i_item.write_data[cpic_pkg::CMD_RR_BIT]) begin
                                    n_ris[k] = i_item.write_data[cpic_pkg::CMD_RIS_BIT];
                                end
                            end else if (w_cmd == cpic_pkg::EOI_NONSPEC ||
                                         w_cmd == cpic_pkg::EOI_ROT_NONSPEC) begin
                                n_svc[k] = r_svc[k] & (r_svc[k] - 8'd1);
                            end else if (w_cmd == cpic_pkg::EOI_SPEC ||
                                         w_cmd == cpic_pkg::EOI_ROT_SPEC) begin
                                n_svc[k][i_item.write_data[2:0]] = 1'b0;
                            end
                        end else begin
                            // Data register: init words two to four, else the mask.
                            case (r_step[k])
                                cpic_pkg::INIT_ICW2: begin
                                    n_base[k] = i_item.write_data & cpic_pkg::BASE_MASK;
                                    n_step[k] = cpic_pkg::INIT_ICW3;
                                end
                                cpic_pkg::INIT_ICW3: begin
                                    n_step[k] = r_icw4[k] ? cpic_pkg::INIT_ICW4
                                                          : cpic_pkg::INIT_IDLE;
                                end
                                cpic_pkg::INIT_ICW4: begin
                                    n_aeoi[k] = i_item.write_data[cpic_pkg::ICW4_AEOI_BIT];
                                    n_step[k] = cpic_pkg::INIT_IDLE;
                                end
                                default: begin
                                    n_mask[k] = i_item.write_data;
                                end
                            endcase
                        end
                    end
                end
            end
            cpic_pkg::OP_READ: begin
                for (int k = 0; k < cpic_pkg::CHIPS; k++) begin
                    if (i_item.chip_select == 1'(k)) begin
                        if (i_item.reg_select) begin
                            o_result.read_data = r_mask[k];
                        end else begin
                            o_result.read_data = r_ris[k] ? r_svc[k] : r_req[k];
                        end
                    end
                end
            end
            cpic_pkg::OP_ACK: begin
                n_req[0] = w_req0_casc;
                if (!w_master_pick.found) begin
                    o_result.read_data = 8'(r_base[0] + {5'd0, cpic_pkg::SPURIOUS_LINE});
                end else if (w_master_pick.line == cpic_pkg::CASCADE_LINE) begin
                    if (!w_slave_pick.found) begin
                        o_result.read_data =
                            8'(r_base[0] + {5'd0, cpic_pkg::SPURIOUS_LINE});
                    end else begin
                        n_req[1] = w_slave_req;
                        n_svc[1] = w_slave_svc;
                        if (!r_aeoi[0]) begin
                            n_svc[0][cpic_pkg::CASCADE_LINE] = 1'b1;
                        end
                        n_req[0][cpic_pkg::CASCADE_LINE] = w_slave_after.found;
                        o_result.read_data = 8'(r_base[1] + {5'd0, w_slave_pick.line});
                    end
                end else begin
                    n_req[0][w_master_pick.line] = 1'b0;
                    if (!r_aeoi[0]) begin
                        n_svc[0][w_master_pick.line] = 1'b1;
                    end
                    o_result.read_data = 8'(r_base[0] + {5'd0, w_master_pick.line});
                end
            end
            cpic_pkg::OP_POLL: begin
                n_req[0] = w_req0_casc;
                o_result.pending = w_master_pick.found;
            end
            default: begin
                o_result = '0;
            end
        endcase
    end

    // State registers, updated once per transfer that enters processing.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < cpic_pkg::CHIPS; k++) begin
                r_req[k]  <= '0;
                r_svc[k]  <= '0;
                r_mask[k] <= cpic_pkg::MASK_RESET;
                r_step[k] <= cpic_pkg::INIT_IDLE;
                r_icw4[k] <= 1'b0;
                r_aeoi[k] <= 1'b0;
                r_ris[k]  <= 1'b0;
            end
            r_base[0] <= cpic_pkg::MASTER_BASE_RESET;
            r_base[1] <= cpic_pkg::SLAVE_BASE_RESET;
        end else if (i_fire) begin
            for (int k = 0; k < cpic_pkg::CHIPS; k++) begin
                r_req[k]  <= n_req[k];
                r_svc[k]  <= n_svc[k];
                r_mask[k] <= n_mask[k];
                r_step[k] <= n_step[k];
                r_icw4[k] <= n_icw4[k];
                r_base[k] <= n_base[k];
                r_aeoi[k] <= n_aeoi[k];
                r_ris[k]  <= n_ris[k];
            end
        end
    end

endmodule

`default_nettype wire

### src/cascaded_priority_interrupt_controller.sv
// Path: an input transfer lands in the input register, then one pass of event logic
// writes the result register, from which the result is offered on the output channel.
// Throughput: one event per cycle unless output stalls; set by the single-pass chip-state update.
// Reset: synchronous, active low; both channels empty, masks all set, vector bases
// 0x08 and 0x70, no requests or in-service bits. Top level; uses cpic_pkg, cpic_if.
`timescale 1ns / 1ps
`default_nettype none

module cascaded_priority_interrupt_controller (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    cpic_in_if.sink      i_in,
    cpic_out_if.source   o_out
);

    logic               r_in_valid;
    cpic_pkg::t_item    r_item;
    logic               r_out_valid;
    cpic_pkg::t_result  r_result;
    cpic_pkg::t_result  w_result;
    logic               w_advance;

    // An item moves into processing when the result register is free or draining.
    assign w_advance  = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item.op          <= i_in.op;
            r_item.irq_line    <= i_in.irq_line;
            r_item.chip_select <= i_in.chip_select;
            r_item.reg_select  <= i_in.reg_select;
            r_item.write_data  <= i_in.write_data;
        end
    end

    // Controller state and event logic.
    cpic_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_advance),
        .i_item   (r_item),
        .o_result (w_result)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_result <= w_result;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.read_data = r_result.read_data;
    assign o_out.pending   = r_result.pending;

endmodule

`default_nettype wire
